FILE: rtl/mqrf_pkg.sv
// shared types, field widths and codes of the multi-queue ring fifo
`timescale 1ns / 1ps

package mqrf_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned MAX_PIPES_DEF  = 16;
  localparam int unsigned MAX_DEPTH_DEF  = 64;
  localparam int unsigned ENTRY_BITS_DEF = 32;

  // fixed field widths of the channels
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 3'd0,
    MODE_DESTROY = 3'd1,
    MODE_PUSH    = 3'd2,
    MODE_POP     = 3'd3,
    MODE_QUERY   = 3'd4
  } mode_e;

  // operation kind after decode, bad modes folded into one code
  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_PUSH    = 3'd2,
    OP_POP     = 3'd3,
    OP_QUERY   = 3'd4,
    OP_BAD     = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_NO_PIPE = 3'd2,
    STS_FULL    = 3'd3,
    STS_EMPTY   = 3'd4
  } status_e;

  // classified operation, carried from front to back
  typedef struct packed {
    op_e               kind;
    logic              id_ok;
    logic              depth_ok;
    logic [ID_W-1:0]   pipe_id;
    logic [REQ_W-1:0]  depth_request;
    logic [DATA_W-1:0] push_data;
  } op_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] pipe_handle;
    logic [DATA_W-1:0]   pop_data;
    logic [COUNT_W-1:0]  occupancy;
    logic [COUNT_W-1:0]  free_entries;
  } rsp_t;

endpackage

FILE: rtl/mqrf_if.sv
// request and response channel interfaces of the multi-queue ring fifo
`timescale 1ns / 1ps

interface mqrf_req_if import mqrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   pipe_id;
  logic [REQ_W-1:0]  depth_request;
  logic [DATA_W-1:0] push_data;

  modport source (output valid, output mode, output pipe_id, output depth_request,
                  output push_data, input ready);
  modport sink (input valid, input mode, input pipe_id, input depth_request,
                input push_data, output ready);
endinterface

interface mqrf_rsp_if import mqrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] pipe_handle;
  logic [DATA_W-1:0]   pop_data;
  logic [COUNT_W-1:0]  occupancy;
  logic [COUNT_W-1:0]  free_entries;

  modport source (output valid, output status, output pipe_handle, output pop_data,
                  output occupancy, output free_entries, input ready);
  modport sink (input valid, input status, input pipe_handle, input pop_data,
                input occupancy, input free_entries, output ready);
endinterface

FILE: rtl/mqrf_front.sv
// front end: accepts request transactions and classifies them
`timescale 1ns / 1ps

module mqrf_front import mqrf_pkg::*; #(
  parameter int unsigned MAX_PIPES = MAX_PIPES_DEF,
  parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
  mqrf_req_if.sink req_i,
  input  logic     q_ready_i,
  output logic     q_push_o,
  output op_t      q_data_o
);

  localparam logic [ID_W:0]  PipesLim = (ID_W + 1)'(MAX_PIPES);
  localparam logic [REQ_W:0] DepthLim = (REQ_W + 1)'(MAX_DEPTH);

  assign req_i.ready = q_ready_i;
  assign q_push_o    = req_i.valid && q_ready_i;

  always_comb begin
    q_data_o.pipe_id       = req_i.pipe_id;
    q_data_o.depth_request = req_i.depth_request;
    q_data_o.push_data     = req_i.push_data;
    q_data_o.id_ok         = {1'b0, req_i.pipe_id} < PipesLim;
    q_data_o.depth_ok      = (req_i.depth_request != '0) &&
                             ({1'b0, req_i.depth_request} <= DepthLim);
    unique case (req_i.mode)
      MODE_CREATE:  q_data_o.kind = OP_CREATE;
      MODE_DESTROY: q_data_o.kind = OP_DESTROY;
      MODE_PUSH:    q_data_o.kind = OP_PUSH;
      MODE_POP:     q_data_o.kind = OP_POP;
      MODE_QUERY:   q_data_o.kind = OP_QUERY;
      default:      q_data_o.kind = OP_BAD;
    endcase
  end

endmodule

FILE: rtl/mqrf_queue.sv
// two-entry queue between front and back end
`timescale 1ns / 1ps

module mqrf_queue import mqrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  data_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/mqrf_back.sv
// back end: pipe records, ring store and result register
`timescale 1ns / 1ps

module mqrf_back import mqrf_pkg::*; #(
  parameter int unsigned MAX_PIPES  = MAX_PIPES_DEF,
  parameter int unsigned MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int unsigned ENTRY_BITS = ENTRY_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  op_t  q_data_i,
  output logic q_pop_o,
  input  logic rsp_ready_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned PIPE_W     = (MAX_PIPES > 1) ? $clog2(MAX_PIPES) : 1;
  localparam int unsigned IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_DEPTH + 1);
  localparam int unsigned REC_W      = 2 * CNT_W + 2 * IDX_W;
  localparam int unsigned RING_DEPTH = MAX_PIPES << IDX_W;
  localparam int unsigned RADDR_W    = PIPE_W + IDX_W;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_LOOK = 3'b010,
    BK_RING = 3'b100
  } bk_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [IDX_W-1:0] rd;
    logic [IDX_W-1:0] wr;
    logic [CNT_W-1:0] cnt;
  } rec_t;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] d);
    logic [CNT_W:0] n;
    n = (CNT_W + 1)'(idx) + 1'b1;
    return (n >= (CNT_W + 1)'(d)) ? '0 : IDX_W'(n);
  endfunction

  bk_state_e             state_q, state_d;
  op_t                   op_q;
  logic [MAX_PIPES-1:0]  in_use_q, in_use_d;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;

  logic [REC_W-1:0]      rec_mem [MAX_PIPES];
  logic [REC_W-1:0]      rec_rd_q;
  logic [ENTRY_BITS-1:0] ring_mem [RING_DEPTH];
  logic [ENTRY_BITS-1:0] ring_rd_q;

  logic                  rec_re, rec_we, ring_re, ring_we;
  logic [PIPE_W-1:0]     rec_waddr;
  rec_t                  rec_wdata, rec;
  logic [RADDR_W-1:0]    ring_addr;
  logic [ENTRY_BITS-1:0] ring_wdata;

  logic                  out_free, pipe_ok, any_free;
  logic [PIPE_W-1:0]     slot, free_idx;
  logic [ID_W-1:0]       free_ext;
  logic [63:0]           push_ext, pop_ext;

  assign rec       = rec_t'(rec_rd_q);
  assign slot      = op_q.pipe_id[PIPE_W-1:0];
  assign pipe_ok   = op_q.id_ok && in_use_q[slot];
  assign out_free  = !rsp_valid_q || rsp_ready_i;
  assign any_free  = ~&in_use_q;
  assign free_ext  = ID_W'(free_idx);
  assign push_ext  = 64'(op_q.push_data);
  assign pop_ext   = 64'(ring_rd_q);
  assign ring_wdata = push_ext[ENTRY_BITS-1:0];

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_PIPES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx = PIPE_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    in_use_d    = in_use_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    q_pop_o     = 1'b0;
    rec_re      = 1'b0;
    rec_we      = 1'b0;
    rec_waddr   = slot;
    rec_wdata   = rec;
    ring_re     = 1'b0;
    ring_we     = 1'b0;
    ring_addr   = {slot, rec.wr};

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rec_re  = q_data_i.id_ok;
          state_d = BK_LOOK;
        end
      end
      BK_LOOK: begin
        if (op_q.kind == OP_POP && pipe_ok && rec.cnt != '0) begin
          // entry comes from the registered ring store read, answered in BK_RING
          ring_re       = 1'b1;
          ring_addr     = {slot, rec.rd};
          rec_we        = 1'b1;
          rec_wdata.rd  = advance(rec.rd, rec.depth);
          rec_wdata.cnt = rec.cnt - 1'b1;
          state_d       = BK_RING;
        end else if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '0;
          rsp_d.status = STS_INVALID;
          state_d     = BK_IDLE;
          case (op_q.kind)
            OP_CREATE: begin
              if (!op_q.depth_ok) begin
                rsp_d.status = STS_INVALID;
              end else if (!any_free) begin
                rsp_d.status = STS_NO_PIPE;
              end else begin
                rsp_d.status        = STS_OK;
                rsp_d.pipe_handle   = free_ext[HANDLE_W-1:0];
                in_use_d[free_idx]  = 1'b1;
                rec_we              = 1'b1;
                rec_waddr           = free_idx;
                rec_wdata           = '0;
                rec_wdata.depth     = op_q.depth_request[CNT_W-1:0];
              end
            end
            OP_DESTROY: begin
              if (pipe_ok) begin
                rsp_d.status   = STS_OK;
                in_use_d[slot] = 1'b0;
              end
            end
            OP_PUSH: begin
              if (pipe_ok) begin
                if (rec.cnt >= rec.depth) begin
                  rsp_d.status = STS_FULL;
                end else begin
                  rsp_d.status  = STS_OK;
                  ring_we       = 1'b1;
                  rec_we        = 1'b1;
                  rec_wdata.wr  = advance(rec.wr, rec.depth);
                  rec_wdata.cnt = rec.cnt + 1'b1;
                end
              end
            end
            OP_POP: begin
              // successful pop is taken above
              if (pipe_ok) begin
                rsp_d.status = STS_EMPTY;
              end
            end
            OP_QUERY: begin
              if (pipe_ok) begin
                rsp_d.status       = STS_OK;
                rsp_d.occupancy    = COUNT_W'(rec.cnt);
                rsp_d.free_entries = COUNT_W'(rec.depth - rec.cnt);
              end
            end
            default: begin
              rsp_d.status = STS_INVALID;
            end
          endcase
        end
      end
      BK_RING: begin
        if (out_free) begin
          rsp_valid_d    = 1'b1;
          rsp_d          = '0;
          rsp_d.status   = STS_OK;
          rsp_d.pop_data = pop_ext[DATA_W-1:0];
          state_d        = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      in_use_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (q_pop_o) begin
      op_q <= q_data_i;
    end
  end

  // pipe record memory, registered read
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= REC_W'(rec_wdata);
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[q_data_i.pipe_id[PIPE_W-1:0]];
    end
  end

  // shared ring store, registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_addr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: rtl/multi_queue_ring_fifo_top.sv
// top level of the multi-queue ring fifo manager
`timescale 1ns / 1ps

// Manages MAX_PIPES independent ring fifos of ENTRY_BITS wide entries that
// share one entry store, each pipe owning MAX_DEPTH store rows rounded up to a
// power of two. Every request transaction (create, destroy, push, pop, query)
// gives exactly one response transaction with a status. The front end accepts a
// request whenever its two-entry queue has room, so requests are still taken,
// until that queue is full, while a response waits on the output register. The
// back end takes one operation at a time: pipe record memory read, then update
// and respond, with a ring store read after the record read for a pop that
// returns an entry. It takes no new operation before the response of the last
// one is registered. In-use flags are cleared at reset, so no clearing pass is
// needed; ring store contents are undefined until pushed.

module multi_queue_ring_fifo_top import mqrf_pkg::*; #(
  parameter int unsigned MAX_PIPES  = MAX_PIPES_DEF,
  parameter int unsigned MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int unsigned ENTRY_BITS = ENTRY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mqrf_req_if.sink   req_i,
  mqrf_rsp_if.source rsp_o
);

  // front to queue
  logic q_push, q_ready;
  op_t  q_in;

  // queue to back end
  logic q_valid, q_pop;
  op_t  q_out;

  // response register
  logic rsp_valid;
  rsp_t rsp;

  mqrf_front #(
    .MAX_PIPES (MAX_PIPES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .req_i     (req_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_data_o  (q_in)
  );

  mqrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  mqrf_back #(
    .MAX_PIPES  (MAX_PIPES),
    .MAX_DEPTH  (MAX_DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  // response channel straight from the back end output register
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.pipe_handle  = rsp.pipe_handle;
  assign rsp_o.pop_data     = rsp.pop_data;
  assign rsp_o.occupancy    = rsp.occupancy;
  assign rsp_o.free_entries = rsp.free_entries;

endmodule

FILE: dv/multi_queue_ring_fifo_top_tb.sv
// self-checking testbench of the multi-queue ring fifo manager
`timescale 1ns / 1ps

import mqrf_pkg::*;

// one request transaction as the driver sends it and the scoreboard sees it
typedef struct packed {
  logic [mqrf_pkg::MODE_W-1:0] mode;
  logic [mqrf_pkg::ID_W-1:0]   pipe_id;
  logic [mqrf_pkg::REQ_W-1:0]  depth_request;
  logic [mqrf_pkg::DATA_W-1:0] push_data;
} ring_op_t;

// keeps a shadow of every pipe and the responses still owed by the block
class ring_fifo_scoreboard;

  localparam int unsigned NUM_PIPES  = MAX_PIPES_DEF;
  localparam int unsigned RING_DEPTH = MAX_DEPTH_DEF;
  localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - ENTRY_BITS_DEF);

  bit                pipe_live  [NUM_PIPES];
  int unsigned       pipe_depth [NUM_PIPES];
  int unsigned       head       [NUM_PIPES];
  int unsigned       tail       [NUM_PIPES];
  int unsigned       fill       [NUM_PIPES];
  logic [DATA_W-1:0] entries    [NUM_PIPES*RING_DEPTH];

  rsp_t        owed_responses[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned status_tally[5];

  task report_mismatch(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // work out the response of one accepted request and advance the shadow state
  function void note_request(ring_op_t op);
    rsp_t        exp_rsp;
    int unsigned s;
    exp_rsp        = '0;
    exp_rsp.status = STS_INVALID;
    if (op.mode == MODE_CREATE) begin
      if (op.depth_request != 0 && op.depth_request <= RING_DEPTH) begin
        exp_rsp.status = STS_NO_PIPE;
        for (s = 0; s < NUM_PIPES; s++) begin
          if (!pipe_live[s]) begin
            pipe_live[s]        = 1'b1;
            pipe_depth[s]       = op.depth_request;
            head[s]             = 0;
            tail[s]             = 0;
            fill[s]             = 0;
            exp_rsp.pipe_handle = HANDLE_W'(s);
            exp_rsp.status      = STS_OK;
            break;
          end
        end
      end
    end else if (op.mode inside {MODE_DESTROY, MODE_PUSH, MODE_POP, MODE_QUERY} &&
                 op.pipe_id < NUM_PIPES && pipe_live[op.pipe_id]) begin
      s = op.pipe_id;
      exp_rsp.status = STS_OK;
      case (op.mode)
        MODE_DESTROY: begin
          pipe_live[s]  = 1'b0;
          pipe_depth[s] = 0;
          head[s]       = 0;
          tail[s]       = 0;
          fill[s]       = 0;
        end
        MODE_PUSH: begin
          if (fill[s] >= pipe_depth[s]) begin
            exp_rsp.status = STS_FULL;
          end else begin
            entries[s*RING_DEPTH + tail[s]] = op.push_data & ENTRY_MASK;
            tail[s] = (tail[s] + 1 >= pipe_depth[s]) ? 0 : tail[s] + 1;
            fill[s]++;
          end
        end
        MODE_POP: begin
          if (fill[s] == 0) begin
            exp_rsp.status = STS_EMPTY;
          end else begin
            exp_rsp.pop_data = entries[s*RING_DEPTH + head[s]];
            head[s] = (head[s] + 1 >= pipe_depth[s]) ? 0 : head[s] + 1;
            fill[s]--;
          end
        end
        default: begin
          exp_rsp.occupancy    = COUNT_W'(fill[s]);
          exp_rsp.free_entries = COUNT_W'(pipe_depth[s] - fill[s]);
        end
      endcase
    end
    status_tally[int'(exp_rsp.status)]++;
    owed_responses.push_back(exp_rsp);
  endfunction

  // compare one response transaction with the oldest owed response
  task check_response(rsp_t got);
    rsp_t exp_rsp;
    if (owed_responses.size() == 0) begin
      report_mismatch($sformatf("response with status %0d arrived unasked", got.status));
      return;
    end
    exp_rsp = owed_responses.pop_front();
    checked++;
    if (got.status !== exp_rsp.status)
      report_mismatch($sformatf("response %0d status %0d, want %0d",
                                checked, got.status, exp_rsp.status));
    if (got.pipe_handle !== exp_rsp.pipe_handle)
      report_mismatch($sformatf("response %0d pipe_handle %0d, want %0d",
                                checked, got.pipe_handle, exp_rsp.pipe_handle));
    if (got.pop_data !== exp_rsp.pop_data)
      report_mismatch($sformatf("response %0d pop_data %08h, want %08h",
                                checked, got.pop_data, exp_rsp.pop_data));
    if (got.occupancy !== exp_rsp.occupancy)
      report_mismatch($sformatf("response %0d occupancy %0d, want %0d",
                                checked, got.occupancy, exp_rsp.occupancy));
    if (got.free_entries !== exp_rsp.free_entries)
      report_mismatch($sformatf("response %0d free_entries %0d, want %0d",
                                checked, got.free_entries, exp_rsp.free_entries));
  endtask
endclass

module multi_queue_ring_fifo_top_tb;
  import mqrf_pkg::*;

  // mode codes that the block has to reject
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

  localparam int unsigned TARGET_OPS = 650;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  mqrf_req_if req_if ();
  mqrf_rsp_if rsp_if ();

  multi_queue_ring_fifo_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ring_fifo_scoreboard sb = new();

  // stretches where a side never idles, toggled now and then
  bit          req_calm = 1'b0;
  bit          rsp_calm = 1'b0;
  int unsigned ops_sent = 0;
  int unsigned directed_ops = 0;

  always #2 clk_i = ~clk_i;

  // both channels are sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_request('{req_if.mode, req_if.pipe_id, req_if.depth_request, req_if.push_data});
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response('{status_e'(rsp_if.status), rsp_if.pipe_handle, rsp_if.pop_data,
                            rsp_if.occupancy, rsp_if.free_entries});
    end
  end

  // one request transaction; entered and left at a falling edge
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] pipe_id,
                         input logic [REQ_W-1:0] depth, input logic [DATA_W-1:0] data);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
    gap = req_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      // idle with junk on the payload
      req_if.valid         <= 1'b0;
      req_if.mode          <= MODE_W'($urandom);
      req_if.pipe_id       <= ID_W'($urandom);
      req_if.depth_request <= REQ_W'($urandom);
      req_if.push_data     <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= mode;
    req_if.pipe_id       <= pipe_id;
    req_if.depth_request <= depth;
    req_if.push_data     <= data;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    ops_sent++;
    @(negedge clk_i);
  endtask

  // pipe ids lean on the low slots, which create hands out first
  function automatic logic [ID_W-1:0] pick_pipe();
    int unsigned r = $urandom_range(0, 99);
    if (r < 85) return ID_W'($urandom_range(0, 7));
    if (r < 95) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 255));
  endfunction

  // mostly small rings so that full and wrap happen often
  function automatic logic [REQ_W-1:0] pick_depth();
    int unsigned r = $urandom_range(0, 99);
    if (r < 70) return REQ_W'($urandom_range(1, 8));
    if (r < 80) return REQ_W'(MAX_DEPTH_DEF);
    if (r < 90) return REQ_W'($urandom_range(9, MAX_DEPTH_DEF - 1));
    return REQ_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random_op();
    int unsigned r = $urandom_range(0, 99);
    logic [MODE_W-1:0] mode;
    if (r < 12)      mode = MODE_CREATE;
    else if (r < 20) mode = MODE_DESTROY;
    else if (r < 55) mode = MODE_PUSH;
    else if (r < 85) mode = MODE_POP;
    else if (r < 95) mode = MODE_QUERY;
    else             mode = MODE_W'($urandom_range(int'(MODE_SPARE_A), int'(MODE_SPARE_C)));
    send_op(mode, pick_pipe(), pick_depth(), $urandom);
  endtask

  // response side: random ready stalls, with calm stretches
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
      gap = rsp_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  // stimulus: reset, directed corner cases, then random traffic
  initial begin
    logic [ID_W-1:0] burst_pipe;
    int unsigned     burst_len;
    int unsigned     push_pct;

    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.mode          = MODE_CREATE;
    req_if.pipe_id       = '0;
    req_if.depth_request = '0;
    req_if.push_data     = '0;
    rsp_if.ready         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // create with a depth of zero, just above the limit, and at the top of the field
    send_op(MODE_CREATE, 8'd0, 8'd0, 32'h0);
    send_op(MODE_CREATE, 8'd0, REQ_W'(MAX_DEPTH_DEF + 1), 32'h0);
    send_op(MODE_CREATE, 8'hff, 8'hff, 32'hffff_ffff);
    // smallest and largest legal rings take slots 0 and 1
    send_op(MODE_CREATE, 8'd0, 8'd1, 32'h0);
    send_op(MODE_CREATE, 8'd0, REQ_W'(MAX_DEPTH_DEF), 32'h0);
    // a one-entry ring: fill, refuse, query, drain, refuse
    send_op(MODE_PUSH, 8'd0, 8'd0, 32'hffff_ffff);
    send_op(MODE_PUSH, 8'd0, 8'd0, 32'h1234_5678);
    send_op(MODE_QUERY, 8'd0, 8'd0, 32'h0);
    send_op(MODE_POP, 8'd0, 8'd0, 32'h0);
    send_op(MODE_POP, 8'd0, 8'd0, 32'h0);
    send_op(MODE_PUSH, 8'd1, 8'd0, 32'h0);
    send_op(MODE_QUERY, 8'd1, 8'd0, 32'h0);
    send_op(MODE_POP, 8'd1, 8'd0, 32'hffff_ffff);
    // ids past the slot range, or of a slot nobody created
    send_op(MODE_QUERY, ID_W'(MAX_PIPES_DEF), 8'd0, 32'h0);
    send_op(MODE_PUSH, 8'hff, 8'd0, 32'h0);
    send_op(MODE_POP, 8'd5, 8'd0, 32'h0);
    // modes with no meaning
    send_op(MODE_SPARE_A, 8'd0, 8'd4, 32'h0);
    send_op(MODE_SPARE_B, 8'd1, 8'd4, 32'h0);
    send_op(MODE_SPARE_C, 8'd0, 8'd0, 32'hffff_ffff);
    // free slot 0, use it dead, then see it claimed again
    send_op(MODE_DESTROY, 8'd0, 8'd0, 32'h0);
    send_op(MODE_PUSH, 8'd0, 8'd0, 32'h5a5a_a5a5);
    send_op(MODE_CREATE, 8'd0, 8'd2, 32'h0);
    send_op(MODE_DESTROY, 8'd200, 8'd0, 32'h0);
    send_op(MODE_QUERY, 8'd0, 8'd0, 32'h0);
    send_op(MODE_DESTROY, 8'd1, 8'd0, 32'h0);
    directed_ops = ops_sent;

    // claim every slot so that a create finds none free
    repeat (MAX_PIPES_DEF + 1) send_op(MODE_CREATE, pick_pipe(), REQ_W'($urandom_range(1, 6)),
                                        $urandom);

    while (ops_sent < TARGET_OPS) begin
      if ($urandom_range(0, 99) < 40) begin
        // burst on one pipe, leaning to pushes or pops to reach full, empty and wrap
        burst_pipe = ID_W'($urandom_range(0, 7));
        burst_len  = $urandom_range(2, 16);
        push_pct   = ($urandom_range(0, 1) == 1) ? 75 : 25;
        repeat (burst_len)
          send_op(($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP, burst_pipe,
                  REQ_W'($urandom), $urandom);
      end else begin
        send_random_op();
      end
    end

    req_if.valid <= 1'b0;
    while (sb.owed_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests (%0d directed), %0d responses checked, %0d mismatches",
             ops_sent, directed_ops, sb.checked, sb.errors);
    $display("statuses seen: ok %0d, invalid %0d, no free pipe %0d, full %0d, empty %0d",
             sb.status_tally[STS_OK], sb.status_tally[STS_INVALID],
             sb.status_tally[STS_NO_PIPE], sb.status_tally[STS_FULL],
             sb.status_tally[STS_EMPTY]);
    if (sb.errors == 0) begin
      $display("PASS multi_queue_ring_fifo_top");
    end else begin
      $display("FAIL multi_queue_ring_fifo_top");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("timeout: %0d requests sent, %0d responses still owed",
             ops_sent, sb.owed_responses.size());
    $display("FAIL multi_queue_ring_fifo_top");
    $finish;
  end

endmodule

FILE: multi_queue_ring_fifo_top.f
rtl/mqrf_pkg.sv
rtl/mqrf_if.sv
rtl/mqrf_front.sv
rtl/mqrf_queue.sv
rtl/mqrf_back.sv
rtl/multi_queue_ring_fifo_top.sv
dv/multi_queue_ring_fifo_top_tb.sv
